// ----- hdl/ilir_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed list package
// Field widths, operation and status codes, controller states and the
// command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package ilir_pkg;

  localparam int KIND_W   = 2;
  localparam int IDX_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_GET    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic rd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic no_move;
    logic last;
  } dp_stat_t;

endpackage

// ----- hdl/ilir_datapath.sv -----
// ----------------------------------------------------------------------------
// Indexed list datapath
// Entry memory, length counter, shift pointers and the result word register.
// ----------------------------------------------------------------------------
module ilir_datapath import ilir_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [IDX_W-1:0]    in_index,
  input  logic [VAL_W-1:0]    in_item_value,
  output logic [STATUS_W-1:0] out_status,
  output logic [VAL_W-1:0]    out_read_value,
  output logic [LEN_W-1:0]    out_list_length
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [KIND_W-1:0]     kind_r;
  logic [IDX_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [CW-1:0]         left_r;
  logic [AW-1:0]         rd_ptr_r;
  logic [AW-1:0]         wb_ptr_r;
  logic                  wb_en_r;
  logic                  first_r;
  logic                  take_r;
  logic [DATA_WIDTH-1:0] rd_q_r;
  logic [DATA_WIDTH-1:0] taken_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [VAL_W-1:0]      out_value_r;
  logic [LEN_W-1:0]      out_len_r;

  logic [CMPW-1:0]       pos_x;
  logic [CMPW-1:0]       cnt_x;
  logic                  is_ins;
  logic                  is_get;
  logic                  is_rem;
  logic                  full;
  status_t               res_status;
  logic [DATA_WIDTH-1:0] res_value;
  logic                  wr_item;

  assign pos_x  = CMPW'(pos_r);
  assign cnt_x  = CMPW'(count_r);
  assign is_ins = (kind_r == KIND_INSERT);
  assign is_get = (kind_r == KIND_GET);
  assign is_rem = (kind_r == KIND_REMOVE);
  assign full   = (count_r == CW'(CAPACITY));

  always_comb begin
    res_status = STATUS_OK;
    case (kind_r)
      KIND_INSERT: begin
        if (pos_x > cnt_x) begin
          res_status = STATUS_RANGE;
        end else if (full) begin
          res_status = STATUS_FULL;
        end
      end
      KIND_GET, KIND_REMOVE: begin
        if (pos_x >= cnt_x) begin
          res_status = STATUS_RANGE;
        end
      end
      default: res_status = STATUS_RANGE;
    endcase
  end

  assign stat.err     = (res_status != STATUS_OK);
  assign stat.no_move = is_ins && (pos_x == cnt_x);
  assign stat.last    = (left_r == CW'(1));

  assign wr_item   = cmd.out_load && !stat.err && is_ins;
  assign res_value = (!stat.err && (is_get || is_rem)) ? taken_r : '0;

  always_comb begin
    count_nxt = count_r;
    if (cmd.out_load && !stat.err) begin
      if (is_ins) begin
        count_nxt = count_r + CW'(1);
      end else if (is_rem) begin
        count_nxt = count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wb_en_r <= 1'b0;
      take_r  <= 1'b0;
      first_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      wb_en_r <= cmd.rd && (is_ins || (is_rem && !first_r));
      take_r  <= cmd.rd && first_r;
      if (cmd.start) begin
        first_r <= 1'b1;
      end else if (cmd.rd) begin
        first_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      pos_r  <= in_index;
      val_r  <= DATA_WIDTH'(in_item_value);
    end
    if (cmd.start) begin
      left_r   <= is_get ? CW'(1) : count_r - CW'(pos_r);
      rd_ptr_r <= is_ins ? AW'(count_r - CW'(1)) : AW'(pos_r);
    end else if (cmd.rd) begin
      left_r   <= left_r - CW'(1);
      rd_ptr_r <= is_ins ? rd_ptr_r - AW'(1) : rd_ptr_r + AW'(1);
    end
    wb_ptr_r <= is_ins ? rd_ptr_r + AW'(1) : rd_ptr_r - AW'(1);
    if (take_r) begin
      taken_r <= rd_q_r;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status;
      out_value_r  <= VAL_W'(res_value);
      out_len_r    <= LEN_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en_r) begin
      mem[wb_ptr_r] <= rd_q_r;
    end else if (wr_item) begin
      mem[AW'(pos_r)] <= val_r;
    end
    if (cmd.rd) begin
      rd_q_r <= mem[rd_ptr_r];
    end
  end

  assign out_status      = out_status_r;
  assign out_read_value  = out_value_r;
  assign out_list_length = out_len_r;

endmodule

// ----- hdl/ilir_controller.sv -----
// ----------------------------------------------------------------------------
// Indexed list controller
// Sequences decode, shift and result phases and owns both handshakes.
// ----------------------------------------------------------------------------
module ilir_controller import ilir_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.err || stat.no_move) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.start = 1'b1;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.rd = 1'b1;
        if (stat.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hdl/indexed_list_insert_remove.sv -----
// ----------------------------------------------------------------------------
// Indexed list with insert, get and remove
// Ordered list of CAPACITY entries held in a one-write, one-read memory.
// ----------------------------------------------------------------------------
// Each input word passes through a decode state, then the entry memory is
// walked one entry per cycle through its single read port, with each
// write-back in the cycle after its read: insert and remove walk
// (length - index) entries, get walks one, and a refused operation or an
// insert at the end of the list skips the walk. The result waits while an
// earlier result is held by out_stall. The finished result sits in an output
// register, so the next word is accepted while it waits to be taken.
module indexed_list_insert_remove import ilir_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [IDX_W-1:0]    in_index,
  input  logic [VAL_W-1:0]    in_item_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [VAL_W-1:0]    out_read_value,
  output logic [LEN_W-1:0]    out_list_length
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ilir_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  ilir_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_index        (in_index),
    .in_item_value   (in_item_value),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_list_length (out_list_length)
  );

endmodule

// ----- hdl/ilir_checker.sv -----
// ----------------------------------------------------------------------------
// Indexed list checker
// Port-level properties of the indexed list, bound to the top level.
// ----------------------------------------------------------------------------
module ilir_checker import ilir_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status,
  input logic [VAL_W-1:0]    out_read_value,
  input logic [LEN_W-1:0]    out_list_length
);

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_FULL) |-> out_list_length == LEN_W'(CAPACITY))
    else $error("full status with length below capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_OK) |-> out_read_value == '0)
    else $error("failed operation returned a value");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted before first was processed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value)
      && $stable(out_status) && $stable(out_list_length))
    else $error("stalled result word changed");

endmodule

bind indexed_list_insert_remove ilir_checker #(.CAPACITY(CAPACITY)) u_ilir_checker (.*);

// ----- dv/indexed_list_insert_remove_tb.sv -----
// ----------------------------------------------------------------------------
// Indexed list insert/remove testbench
// Drives insert, get and remove words with random gaps on both channels,
// predicts each result from a shadow list and checks it field by field.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ilir_pkg::*;

  localparam int CAPACITY = 64;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SETTLE_CYCLES = 80;
  localparam int REPORT_LIMIT = 10;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;
  localparam logic [VAL_W-1:0] VAL_ONES = '1;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  index;
    logic [VAL_W-1:0]  value;
  } list_word_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    value;
    logic [LEN_W-1:0]    length;
  } list_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind = KIND_INSERT;
  logic [IDX_W-1:0]    in_index = '0;
  logic [VAL_W-1:0]    in_item_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [VAL_W-1:0]    out_read_value;
  logic [LEN_W-1:0]    out_list_length;

  list_word_t   pending_words[$];
  list_result_t list_results_due[$];
  logic [VAL_W-1:0] shadow_list[$];

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  words_queued = 0;
  int  words_accepted = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  gen_len = 0;
  bit  gen_filling = 1'b1;
  logic word_taken = 1'b0;

  indexed_list_insert_remove #(
    .CAPACITY(CAPACITY),
    .DATA_WIDTH(VAL_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_index(in_index),
    .in_item_value(in_item_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_read_value(out_read_value),
    .out_list_length(out_list_length)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic list_result_t apply_list_op(logic [KIND_W-1:0] kind,
                                                 logic [IDX_W-1:0] idx,
                                                 logic [VAL_W-1:0] val);
    list_result_t r;
    r.status = STATUS_RANGE;
    r.value = '0;
    case (kind)
      KIND_INSERT: begin
        if (idx <= shadow_list.size()) begin
          if (shadow_list.size() >= CAPACITY) begin
            r.status = STATUS_FULL;
          end else begin
            shadow_list.insert(idx, val);
            r.status = STATUS_OK;
          end
        end
      end
      KIND_GET: begin
        if (idx < shadow_list.size()) begin
          r.value = shadow_list[idx];
          r.status = STATUS_OK;
        end
      end
      KIND_REMOVE: begin
        if (idx < shadow_list.size()) begin
          r.value = shadow_list[idx];
          shadow_list.delete(idx);
          r.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    r.length = LEN_W'(shadow_list.size());
    return r;
  endfunction

  task automatic queue_word(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] val);
    list_word_t w;
    w.kind = kind;
    w.index = idx;
    w.value = val;
    pending_words.push_back(w);
    words_queued++;
    if (kind == KIND_INSERT && idx <= gen_len && gen_len < CAPACITY) begin
      gen_len++;
    end else if (kind == KIND_REMOVE && idx < gen_len) begin
      gen_len--;
    end
  endtask

  task automatic queue_random_words(input int count);
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  val;
    int roll;
    for (int i = 0; i < count; i++) begin
      if (gen_len == 0) begin
        gen_filling = 1'b1;
      end else if (gen_len == CAPACITY && $urandom_range(0, 3) == 0) begin
        gen_filling = 1'b0;
      end else if ($urandom_range(0, 63) == 0) begin
        gen_filling = !gen_filling;
      end
      roll = $urandom_range(0, 9);
      val = (roll == 0) ? '0 : (roll == 1) ? VAL_ONES : VAL_W'($urandom);
      if ($urandom_range(0, 99) < 12) begin
        kind = KIND_W'($urandom_range(0, 3));
        idx = IDX_W'($urandom_range(0, 127));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < (gen_filling ? 60 : 20)) begin
          kind = KIND_INSERT;
        end else if (roll < (gen_filling ? 80 : 40)) begin
          kind = KIND_GET;
        end else begin
          kind = KIND_REMOVE;
        end
        if (kind == KIND_INSERT) begin
          idx = IDX_W'($urandom_range(0, gen_len));
        end else if (gen_len == 0) begin
          idx = '0;
        end else begin
          idx = IDX_W'($urandom_range(0, gen_len - 1));
        end
      end
      queue_word(kind, idx, val);
    end
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued || list_results_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // driver: hold a stalled word, advance once it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_kind <= pending_words[0].kind;
        in_index <= pending_words[0].index;
        in_item_value <= pending_words[0].value;
        pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  // monitor: check the result word first, then predict the accepted input word
  always @(posedge clk) begin
    list_result_t due;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (list_results_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("unexpected result word: status %0d value %h length %0d",
                     out_status, out_read_value, out_list_length);
          end
        end else begin
          due = list_results_due.pop_front();
          if (out_status !== due.status || out_read_value !== due.value ||
              out_list_length !== due.length) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("mismatch: exp status %0d value %h length %0d, got %0d %h %0d",
                       due.status, due.value, due.length,
                       out_status, out_read_value, out_list_length);
            end
          end
        end
      end
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        list_results_due.push_back(apply_list_op(in_kind, in_index, in_item_value));
        words_accepted++;
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 30;
    stall_pct = 71;
    queue_word(KIND_GET, '0, '0);
    queue_word(KIND_REMOVE, '0, '0);
    queue_word(KIND_INSERT, 7'd1, 32'h1111_1111);
    queue_word(KIND_UNUSED, '0, VAL_ONES);
    queue_word(KIND_INSERT, '0, '0);
    queue_word(KIND_INSERT, 7'd1, VAL_ONES);
    queue_word(KIND_INSERT, '0, 32'hA5A5_A5A5);
    queue_word(KIND_INSERT, 7'd4, 32'h2222_2222);
    queue_word(KIND_INSERT, 7'd3, 32'h5A5A_5A5A);
    queue_word(KIND_GET, '0, '0);
    queue_word(KIND_GET, 7'd1, '0);
    queue_word(KIND_GET, 7'd2, '0);
    queue_word(KIND_GET, 7'd3, VAL_ONES);
    queue_word(KIND_GET, 7'd4, '0);
    queue_word(KIND_GET, IDX_MAX, '0);
    queue_word(KIND_REMOVE, IDX_MAX, '0);
    queue_word(KIND_INSERT, IDX_MAX, VAL_ONES);
    queue_word(KIND_REMOVE, 7'd1, '0);
    queue_word(KIND_REMOVE, 7'd2, '0);
    queue_word(KIND_REMOVE, '0, '0);
    queue_word(KIND_GET, '0, '0);
    queue_word(KIND_UNUSED, IDX_MAX, VAL_ONES);
    queue_random_words(380);
    wait_drained();

    send_idle_pct = 71;
    stall_pct = 30;
    queue_random_words(400);
    wait_drained();

    send_idle_pct = 0;
    stall_pct = 0;
    queue_random_words(400);
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && list_results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ilir_pkg.sv
hdl/ilir_datapath.sv
hdl/ilir_controller.sv
hdl/indexed_list_insert_remove.sv
hdl/ilir_checker.sv
dv/indexed_list_insert_remove_tb.sv
